@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Implication a |-> b, sampled on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication a |=> b.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/trd_pkg.sv @@
package trd_pkg;

   localparam int MAX_LEN_W   = 16;
   localparam int MODE_W      = 12;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LEN  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_MODE = 1'd1;

   localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET   = 16'd4096;
   localparam logic [MODE_W-1:0]    INIT_MODE_RESET = 12'o0600;

   localparam logic [7:0] KIND_INFO = 8'd3;
   localparam logic [7:0] KIND_ERR  = 8'd5;
   localparam logic [7:0] KIND_MODE = 8'd6;
   localparam logic [7:0] KIND_DATA = 8'd7;

   localparam logic [2:0] EV_DATA     = 3'd0;
   localparam logic [2:0] EV_INFO     = 3'd1;
   localparam logic [2:0] EV_ERR      = 3'd2;
   localparam logic [2:0] EV_MODE     = 3'd3;
   localparam logic [2:0] EV_ILLEGAL  = 3'd4;
   localparam logic [2:0] EV_COMPLETE = 3'd5;
   localparam logic [2:0] EV_FAILED   = 3'd6;

   localparam logic [1:0] CAUSE_NONE   = 2'd0;
   localparam logic [1:0] CAUSE_END    = 2'd1;
   localparam logic [1:0] CAUSE_LENGTH = 2'd2;
   localparam logic [1:0] CAUSE_REMOTE = 2'd3;

   typedef struct packed {
      logic [2:0]        event_res;
      logic [7:0]        payload_byte;
      logic              byte_valid;
      logic              record_end;
      logic [MODE_W-1:0] file_mode;
      logic [1:0]        failure_cause;
      logic [7:0]        record_kind;
   } rsp_type;

endpackage

@@ rtl/typed_record_receive_deframer_top.sv @@
// Typed record receive deframer.
// Request channel (req_valid/req_ready): one received byte per request, or
// req_stream_end high when the link has closed. Records are a type byte, a
// little-endian 16-bit length and the payload.
// Response channel (rsp_valid/rsp_ready): zero or one result per request,
// carrying event, payload byte, record end, file mode, failure cause, kind.
// CSR port: csr_we with csr_index 0 sets the largest record length, index
// 1 sets the initial file mode (and the current mode). Write only when idle.
// Output: results go into a two-entry output queue and leave it in order.
// Throughput: one request per cycle while the queue has room; the parser
// updates its state in the same cycle and queues the result.
// Stall: while the receiver holds rsp_ready low, requests keep being taken
// until the queue holds two results; req_ready then drops until one leaves.
// Once the transfer completes or fails, later requests are taken and dropped.
// Reset: parser waits for a type byte, max length 4096, mode 0600 octal,
// output queue empty.
module typed_record_receive_deframer_top
   import trd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_rx_byte,
   input  logic                   req_stream_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_event_res,
   output logic [7:0]             rsp_payload_byte,
   output logic                   rsp_byte_valid,
   output logic                   rsp_record_end,
   output logic [MODE_W-1:0]      rsp_file_mode,
   output logic [1:0]             rsp_failure_cause,
   output logic [7:0]             rsp_record_kind,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic    accept;
   logic    emit;
   rsp_type result;
   rsp_type out_data;

   assign accept = req_valid && req_ready;

   trd_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .stream_end (req_stream_end),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .emit       (emit),
      .result     (result)
   );

   trd_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (result),
      .not_full  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_event_res     = out_data.event_res;
   assign rsp_payload_byte  = out_data.payload_byte;
   assign rsp_byte_valid    = out_data.byte_valid;
   assign rsp_record_end    = out_data.record_end;
   assign rsp_file_mode     = out_data.file_mode;
   assign rsp_failure_cause = out_data.failure_cause;
   assign rsp_record_kind   = out_data.record_kind;

endmodule

@@ rtl/trd_parse.sv @@
module trd_parse
   import trd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   input  logic                   stream_end,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   emit,
   output rsp_type                result
);

   localparam logic [2:0] PH_TYPE  = 3'd0;
   localparam logic [2:0] PH_LENLO = 3'd1;
   localparam logic [2:0] PH_LENHI = 3'd2;
   localparam logic [2:0] PH_BODY  = 3'd3;
   localparam logic [2:0] PH_DONE  = 3'd4;

   logic [2:0]           phase_ff, phase_in;
   logic [7:0]           type_ff, type_in;
   logic [7:0]           len_low_ff, len_low_in;
   logic [15:0]          left_ff, left_in;
   logic [1:0]           index_ff, index_in;
   logic [7:0]           mode_low_ff, mode_low_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [MAX_LEN_W-1:0] max_len_ff;

   logic        close_en;
   logic [7:0]  close_byte;
   logic        close_valid;
   logic [15:0] length;
   logic [15:0] left_dec;

   always_comb begin
      phase_in    = phase_ff;
      type_in     = type_ff;
      len_low_in  = len_low_ff;
      left_in     = left_ff;
      index_in    = index_ff;
      mode_low_in = mode_low_ff;
      mode_in     = mode_ff;
      emit        = 1'b0;
      result      = '0;
      close_en    = 1'b0;
      close_byte  = 8'd0;
      close_valid = 1'b0;
      length      = {rx_byte, len_low_ff};
      left_dec    = left_ff - 16'd1;

      if (accept && phase_ff != PH_DONE) begin
         if (stream_end) begin
            phase_in             = PH_DONE;
            emit                 = 1'b1;
            result.event_res     = EV_FAILED;
            result.failure_cause = CAUSE_END;
            result.record_end    = (phase_ff != PH_TYPE);
            result.record_kind   = (phase_ff != PH_TYPE) ? type_ff : 8'd0;
         end else begin
            case (phase_ff)
               PH_TYPE: begin
                  type_in  = rx_byte;
                  phase_in = PH_LENLO;
               end
               PH_LENLO: begin
                  len_low_in = rx_byte;
                  phase_in   = PH_LENHI;
               end
               PH_LENHI: begin
                  if (length > max_len_ff) begin
                     phase_in             = PH_DONE;
                     emit                 = 1'b1;
                     result.event_res     = EV_FAILED;
                     result.record_end    = 1'b1;
                     result.failure_cause = CAUSE_LENGTH;
                     result.record_kind   = type_ff;
                  end else begin
                     left_in     = length;
                     index_in    = 2'd0;
                     mode_low_in = 8'd0;
                     if (length == 16'd0) begin
                        if (type_ff == KIND_MODE) begin
                           mode_in = '0;
                        end
                        close_en = 1'b1;
                     end else begin
                        phase_in = PH_BODY;
                     end
                  end
               end
               PH_BODY: begin
                  if (type_ff == KIND_MODE) begin
                     if (index_ff == 2'd0) begin
                        mode_low_in = rx_byte;
                        mode_in     = {4'd0, rx_byte};
                     end else if (index_ff == 2'd1) begin
                        mode_in = {rx_byte[3:0], mode_low_ff};
                     end
                  end
                  if (index_ff != 2'd2) begin
                     index_in = index_ff + 2'd1;
                  end
                  left_in = left_dec;
                  if (left_dec == 16'd0) begin
                     close_en    = 1'b1;
                     close_byte  = rx_byte;
                     close_valid = 1'b1;
                  end else if (type_ff == KIND_DATA || type_ff == KIND_INFO
                               || type_ff == KIND_ERR) begin
                     emit                = 1'b1;
                     result.payload_byte = rx_byte;
                     result.byte_valid   = 1'b1;
                     result.record_kind  = type_ff;
                     if (type_ff == KIND_DATA) begin
                        result.event_res = EV_DATA;
                     end else if (type_ff == KIND_INFO) begin
                        result.event_res = EV_INFO;
                     end else begin
                        result.event_res = EV_ERR;
                     end
                  end
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end

      // record close: last payload byte, or header of an empty record
      if (close_en) begin
         phase_in            = PH_TYPE;
         emit                = 1'b1;
         result.payload_byte = close_byte;
         result.byte_valid   = close_valid;
         result.record_end   = 1'b1;
         result.record_kind  = type_ff;
         case (type_ff)
            KIND_DATA: begin
               if (close_valid) begin
                  result.event_res = EV_DATA;
               end else begin
                  phase_in         = PH_DONE;
                  result.event_res = EV_COMPLETE;
                  result.file_mode = mode_in;
               end
            end
            KIND_INFO: begin
               result.event_res = EV_INFO;
            end
            KIND_ERR: begin
               phase_in             = PH_DONE;
               result.event_res     = EV_FAILED;
               result.failure_cause = CAUSE_REMOTE;
            end
            KIND_MODE: begin
               result.event_res = EV_MODE;
               result.file_mode = mode_in;
            end
            default: begin
               result.event_res = EV_ILLEGAL;
            end
         endcase
      end

      // initial mode write also loads the current mode
      if (csr_we && csr_index == CSR_INIT_MODE) begin
         mode_in = csr_wdata[MODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TYPE;
         type_ff     <= 8'd0;
         len_low_ff  <= 8'd0;
         left_ff     <= 16'd0;
         index_ff    <= 2'd0;
         mode_low_ff <= 8'd0;
         mode_ff     <= INIT_MODE_RESET;
         max_len_ff  <= MAX_LEN_RESET;
      end else begin
         phase_ff    <= phase_in;
         type_ff     <= type_in;
         len_low_ff  <= len_low_in;
         left_ff     <= left_in;
         index_ff    <= index_in;
         mode_low_ff <= mode_low_in;
         mode_ff     <= mode_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_LEN: begin
                  max_len_ff <= csr_wdata[MAX_LEN_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

@@ rtl/trd_outq.sv @@
module trd_outq
   import trd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    not_full,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   rsp_type    mem_ff [2];
   logic       head_ff, head_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   logic       wr_ptr;

   assign not_full  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[head_ff];
   assign pop       = out_valid && out_ready;
   assign wr_ptr    = head_ff ^ count_ff[0];

   always_comb begin
      head_in  = pop ? ~head_ff : head_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr] <= push_data;
      end
   end

endmodule

@@ rtl/trd_checker.sv @@
`include "assert_macros.svh"

module trd_checker
   import trd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [2:0]        rsp_event_res,
   input logic [7:0]        rsp_payload_byte,
   input logic              rsp_byte_valid,
   input logic [MODE_W-1:0] rsp_file_mode,
   input logic [1:0]        rsp_failure_cause
);

   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_IMPL(a_cause_only_on_fail, clock, reset,
                rsp_valid && rsp_event_res != EV_FAILED, rsp_failure_cause == CAUSE_NONE)
   `ASSERT_IMPL(a_byte_zero_when_empty, clock, reset,
                rsp_valid && !rsp_byte_valid, rsp_payload_byte == 8'd0)
   `ASSERT_IMPL(a_mode_only_when_set, clock, reset,
                rsp_valid && rsp_event_res != EV_MODE && rsp_event_res != EV_COMPLETE,
                rsp_file_mode == '0)

endmodule

bind typed_record_receive_deframer_top trd_checker u_checker (.*);

@@ dv/typed_record_receive_deframer_top_tb.sv @@
`timescale 1ns / 1ps

module typed_record_receive_deframer_top_tb
   import trd_pkg::*;
;

   typedef enum logic [2:0] {
      AWAIT_TYPE, AWAIT_LEN_LO, AWAIT_LEN_HI, IN_BODY, FINISHED
   } parse_phase_type;

   typedef enum {
      END_COMPLETE, END_REMOTE_ERROR, END_OVERSIZE, END_CLOSED_IDLE, END_CLOSED_OPEN
   } finish_kind_type;

   typedef struct {
      logic [7:0] b;
      bit         typed;
      bit         has;
      rsp_type    rsp;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_rx_byte;
   logic                   req_stream_end;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [2:0]             rsp_event_res;
   logic [7:0]             rsp_payload_byte;
   logic                   rsp_byte_valid;
   logic                   rsp_record_end;
   logic [MODE_W-1:0]      rsp_file_mode;
   logic [1:0]             rsp_failure_cause;
   logic [7:0]             rsp_record_kind;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   typed_record_receive_deframer_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .req_stream_end    (req_stream_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_res     (rsp_event_res),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_record_end    (rsp_record_end),
      .rsp_file_mode     (rsp_file_mode),
      .rsp_failure_cause (rsp_failure_cause),
      .rsp_record_kind   (rsp_record_kind),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // parser shadow state
   logic [MAX_LEN_W-1:0] cfg_max_len;
   logic [MODE_W-1:0]    cfg_init_mode;
   parse_phase_type      ph;
   logic [7:0]           cur_kind;
   logic [7:0]           len_lo;
   logic [15:0]          left;
   logic [1:0]           pidx;
   logic [7:0]           mode_lo;
   logic [MODE_W-1:0]    cur_mode;

   rsp_type         pending_events[$];
   stim_row_type    stim_rows[$];
   rsp_type         want_ev;
   rsp_type         got_ev;
   bit              calm;
   int              stall_left;
   int              fails;
   int              bytes_sent;
   int              events_checked;
   int              setting_changes;
   finish_kind_type finish_kind;

   always #1 clock = ~clock;

   function automatic rsp_type make_rsp(input logic [2:0] ev, input logic [7:0] pb,
                                        input logic bv, input logic re,
                                        input logic [MODE_W-1:0] fm, input logic [1:0] fc,
                                        input logic [7:0] kd);
      rsp_type r;
      r.event_res     = ev;
      r.payload_byte  = bv ? pb : 8'd0;
      r.byte_valid    = bv;
      r.record_end    = re;
      r.file_mode     = fm;
      r.failure_cause = fc;
      r.record_kind   = kd;
      return r;
   endfunction

   task automatic close_record(input logic [7:0] b, input logic v, output rsp_type r);
      ph = AWAIT_TYPE;
      case (cur_kind)
         KIND_DATA: begin
            if (!v) begin
               ph = FINISHED;
               r = make_rsp(EV_COMPLETE, 8'd0, 1'b0, 1'b1, cur_mode, CAUSE_NONE, cur_kind);
            end else begin
               r = make_rsp(EV_DATA, b, 1'b1, 1'b1, '0, CAUSE_NONE, cur_kind);
            end
         end
         KIND_INFO: r = make_rsp(EV_INFO, b, v, 1'b1, '0, CAUSE_NONE, cur_kind);
         KIND_ERR: begin
            ph = FINISHED;
            r = make_rsp(EV_FAILED, b, v, 1'b1, '0, CAUSE_REMOTE, cur_kind);
         end
         KIND_MODE: r = make_rsp(EV_MODE, b, v, 1'b1, cur_mode, CAUSE_NONE, cur_kind);
         default: r = make_rsp(EV_ILLEGAL, b, v, 1'b1, '0, CAUSE_NONE, cur_kind);
      endcase
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic e,
                             output bit has, output rsp_type r);
      logic [15:0] len;
      logic        open;
      has = 0;
      r = '0;
      if (ph == FINISHED) begin
         has = 0;
      end else if (e) begin
         open = (ph != AWAIT_TYPE);
         has = 1;
         r = make_rsp(EV_FAILED, 8'd0, 1'b0, open, '0, CAUSE_END, open ? cur_kind : 8'd0);
         ph = FINISHED;
      end else begin
         case (ph)
            AWAIT_TYPE: begin
               cur_kind = b;
               ph = AWAIT_LEN_LO;
            end
            AWAIT_LEN_LO: begin
               len_lo = b;
               ph = AWAIT_LEN_HI;
            end
            AWAIT_LEN_HI: begin
               len = {b, len_lo};
               if (len > cfg_max_len) begin
                  ph = FINISHED;
                  has = 1;
                  r = make_rsp(EV_FAILED, 8'd0, 1'b0, 1'b1, '0, CAUSE_LENGTH, cur_kind);
               end else begin
                  left = len;
                  pidx = 2'd0;
                  mode_lo = 8'd0;
                  if (len == 16'd0) begin
                     if (cur_kind == KIND_MODE) cur_mode = '0;
                     has = 1;
                     close_record(8'd0, 1'b0, r);
                  end else begin
                     ph = IN_BODY;
                  end
               end
            end
            IN_BODY: begin
               if (cur_kind == KIND_MODE) begin
                  if (pidx == 2'd0) begin
                     mode_lo = b;
                     cur_mode = {4'd0, b};
                  end else if (pidx == 2'd1) begin
                     cur_mode = {b[3:0], mode_lo};
                  end
               end
               if (pidx < 2'd2) pidx = pidx + 2'd1;
               left = left - 16'd1;
               if (left == 16'd0) begin
                  has = 1;
                  close_record(b, 1'b1, r);
               end else if (cur_kind == KIND_DATA) begin
                  has = 1;
                  r = make_rsp(EV_DATA, b, 1'b1, 1'b0, '0, CAUSE_NONE, cur_kind);
               end else if (cur_kind == KIND_INFO) begin
                  has = 1;
                  r = make_rsp(EV_INFO, b, 1'b1, 1'b0, '0, CAUSE_NONE, cur_kind);
               end else if (cur_kind == KIND_ERR) begin
                  has = 1;
                  r = make_rsp(EV_ERR, b, 1'b1, 1'b0, '0, CAUSE_NONE, cur_kind);
               end
            end
            default: has = 0;
         endcase
      end
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic push_byte(input logic [7:0] b, input logic e, input bit typed,
                            input bit typed_has, input rsp_type typed_rsp);
      bit      has;
      rsp_type r;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_rx_byte    <= b;
      req_stream_end <= e;
      do @(posedge clock); while (!req_ready);
      parse_byte(b, e, has, r);
      if (typed) begin
         has = typed_has;
         r = typed_rsp;
      end
      if (has) pending_events.push_back(r);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send(input logic [7:0] b);
      push_byte(b, 1'b0, 0, 0, '0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_events.size() != 0);
   endtask

   task automatic apply_settings(input logic [15:0] max_len, input logic [15:0] mode_word);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_LEN;
      csr_wdata <= max_len;
      cfg_max_len = max_len;
      @(negedge clock);
      csr_index <= CSR_INIT_MODE;
      csr_wdata <= mode_word;
      cfg_init_mode = mode_word[MODE_W-1:0];
      cur_mode = cfg_init_mode;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      setting_changes++;
   endtask

   task automatic send_record(input logic [7:0] kind, input int len);
      send(kind);
      send(len[7:0]);
      send(len[15:8]);
      for (int i = 0; i < len; i++) send(8'($urandom_range(0, 255)));
   endtask

   task automatic random_phase(input int n_items);
      int          count;
      int          cap;
      int          len;
      int          pick;
      logic [7:0]  kind;
      count = 0;
      while (count < n_items) begin
         cap = ($urandom_range(0, 9) == 0) ? 40 : 8;
         if (int'(cfg_max_len) < cap) cap = int'(cfg_max_len);
         len = $urandom_range(0, cap);
         pick = $urandom_range(0, 9);
         if (pick < 3) kind = KIND_DATA;
         else if (pick < 5) kind = KIND_INFO;
         else if (pick < 7) kind = KIND_MODE;
         else kind = 8'($urandom_range(0, 255));
         if (kind == KIND_ERR) kind = KIND_INFO;
         if (kind == KIND_DATA && len == 0) kind = KIND_INFO;
         send_record(kind, len);
         count += 3 + len;
         if ($urandom_range(0, 99) == 0) wait_drained();
      end
   endtask

   task automatic finish_transfer();
      int          len;
      int          cap;
      int          n;
      logic [7:0]  frame[$];
      finish_kind = finish_kind_type'($urandom_range(0, 4));
      case (finish_kind)
         END_COMPLETE: send_record(KIND_DATA, 0);
         END_REMOTE_ERROR: begin
            cap = (cfg_max_len < 16'd4) ? int'(cfg_max_len) : 4;
            send_record(KIND_ERR, $urandom_range(0, cap));
         end
         END_OVERSIZE: begin
            len = $urandom_range(int'(cfg_max_len) + 1, 65535);
            send(8'($urandom_range(0, 255)));
            send(len[7:0]);
            send(len[15:8]);
         end
         END_CLOSED_IDLE: push_byte(8'($urandom_range(0, 255)), 1'b1, 0, 0, '0);
         default: begin
            cap = (cfg_max_len < 16'd8) ? int'(cfg_max_len) : 8;
            len = $urandom_range(1, cap);
            frame.push_back(($urandom_range(0, 1) == 0) ? KIND_DATA : KIND_MODE);
            frame.push_back(len[7:0]);
            frame.push_back(len[15:8]);
            for (int i = 0; i < len; i++) frame.push_back(8'($urandom_range(0, 255)));
            n = $urandom_range(1, len + 2);
            for (int i = 0; i < n; i++) send(frame[i]);
            push_byte(8'($urandom_range(0, 255)), 1'b1, 0, 0, '0);
         end
      endcase
      // everything after the finish is dropped
      for (int i = 0; i < 40; i++)
         push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0, 0, '0);
   endtask

   task automatic row_quiet(input logic [7:0] b);
      stim_row_type row;
      row.b = b;
      row.typed = 1;
      row.has = 0;
      row.rsp = '0;
      stim_rows.push_back(row);
   endtask

   task automatic row_event(input logic [7:0] b, input rsp_type r);
      stim_row_type row;
      row.b = b;
      row.typed = 1;
      row.has = 1;
      row.rsp = r;
      stim_rows.push_back(row);
   endtask

   task automatic row_pred(input logic [7:0] b);
      stim_row_type row;
      row.b = b;
      row.typed = 0;
      row.has = 0;
      row.rsp = '0;
      stim_rows.push_back(row);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fails++;
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!calm && !reset && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 12);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_ev = {rsp_event_res, rsp_payload_byte, rsp_byte_valid, rsp_record_end,
                   rsp_file_mode, rsp_failure_cause, rsp_record_kind};
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected event, expected none, actual %p", $time, got_ev);
            fails++;
         end else begin
            want_ev = pending_events.pop_front();
            check_field("event_res", 16'(want_ev.event_res), 16'(got_ev.event_res));
            check_field("payload_byte", 16'(want_ev.payload_byte),
                        16'(got_ev.payload_byte));
            check_field("byte_valid", 16'(want_ev.byte_valid), 16'(got_ev.byte_valid));
            check_field("record_end", 16'(want_ev.record_end), 16'(got_ev.record_end));
            check_field("file_mode", 16'(want_ev.file_mode), 16'(got_ev.file_mode));
            check_field("failure_cause", 16'(want_ev.failure_cause),
                        16'(got_ev.failure_cause));
            check_field("record_kind", 16'(want_ev.record_kind), 16'(got_ev.record_kind));
            events_checked++;
         end
      end
   end

   initial begin
      #1000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'd0;
      req_stream_end = 1'b0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_MAX_LEN;
      csr_wdata = '0;
      calm = 0;
      stall_left = 0;
      fails = 0;
      bytes_sent = 0;
      events_checked = 0;
      setting_changes = 0;

      cfg_max_len = MAX_LEN_RESET;
      cfg_init_mode = INIT_MODE_RESET;
      cur_mode = INIT_MODE_RESET;
      ph = AWAIT_TYPE;
      cur_kind = 8'd0;
      len_lo = 8'd0;
      left = 16'd0;
      pidx = 2'd0;
      mode_lo = 8'd0;

      // zero-length info
      row_quiet(KIND_INFO); row_quiet(8'h00);
      row_event(8'h00, make_rsp(EV_INFO, 8'd0, 1'b0, 1'b1, '0, CAUSE_NONE, KIND_INFO));
      // two data bytes
      row_quiet(KIND_DATA); row_quiet(8'h02); row_quiet(8'h00);
      row_event(8'hAA, make_rsp(EV_DATA, 8'hAA, 1'b1, 1'b0, '0, CAUSE_NONE, KIND_DATA));
      row_event(8'h55, make_rsp(EV_DATA, 8'h55, 1'b1, 1'b1, '0, CAUSE_NONE, KIND_DATA));
      // zero-length mode clears the mode
      row_quiet(KIND_MODE); row_quiet(8'h00);
      row_event(8'h00, make_rsp(EV_MODE, 8'd0, 1'b0, 1'b1, '0, CAUSE_NONE, KIND_MODE));
      // mode from all-ones bytes, third byte ignored for the mode
      row_quiet(KIND_MODE); row_quiet(8'h03); row_quiet(8'h00);
      row_quiet(8'hFF); row_quiet(8'hFF); row_pred(8'h12);
      // unknown types
      row_quiet(8'hFF); row_quiet(8'h01); row_quiet(8'h00);
      row_event(8'h00, make_rsp(EV_ILLEGAL, 8'h00, 1'b1, 1'b1, '0, CAUSE_NONE, 8'hFF));
      row_quiet(8'h00); row_quiet(8'h00);
      row_event(8'h00, make_rsp(EV_ILLEGAL, 8'd0, 1'b0, 1'b1, '0, CAUSE_NONE, 8'h00));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_rows[i])
         push_byte(stim_rows[i].b, 1'b0, stim_rows[i].typed, stim_rows[i].has,
                   stim_rows[i].rsp);

      apply_settings(16'd0, 16'hFFFF);
      random_phase(150);
      apply_settings(16'hFFFF, 16'h0000);
      random_phase(300);
      apply_settings(16'd1, 16'($urandom_range(0, 65535)));
      random_phase(250);
      for (int p = 0; p < 3; p++) begin
         apply_settings(16'($urandom_range(2, 100)), 16'($urandom_range(0, 65535)));
         random_phase(270);
      end
      apply_settings(16'($urandom_range(1, 4000)), 16'($urandom_range(0, 65535)));
      calm = 1;
      random_phase(150);
      finish_transfer();

      wait_drained();
      repeat (20) @(negedge clock);
      if (pending_events.size() != 0) begin
         $display("%0t: %0d events never arrived", $time, pending_events.size());
         fails++;
      end
      $display("Sent %0d request bytes over %0d setting changes, checked %0d events.",
               bytes_sent, setting_changes, events_checked);
      $display("Transfer ended by %s, trailing requests dropped as expected.",
               finish_kind.name());
      if (fails == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/trd_pkg.sv
rtl/trd_parse.sv
rtl/trd_outq.sv
rtl/typed_record_receive_deframer_top.sv
rtl/trd_checker.sv
dv/typed_record_receive_deframer_top_tb.sv
